### rtl/gaps_pkg.sv
`timescale 1ns / 1ps
package gaps_pkg;

  localparam int GridW   = 8;
  localparam int GridH   = 8;
  localparam int NCells  = GridW * GridH;
  localparam int CoordW  = 3;
  localparam int CellW   = 6;
  localparam int CountW  = 7;
  localparam int WeightW = 10;
  localparam int ScoreW  = 12;

  localparam logic [WeightW-1:0] InitWeight = 10'd1000;
  localparam logic [WeightW-1:0] StepCost   = 10'd10;

  typedef logic [CellW-1:0]  cell_t;
  typedef logic [CoordW-1:0] coord_t;

  typedef enum logic [1:0] {
    NB_UP    = 2'd0,
    NB_LEFT  = 2'd1,
    NB_RIGHT = 2'd2,
    NB_DOWN  = 2'd3
  } nb_dir_t;

  typedef enum logic [0:0] {
    REQ_MAP_WRITE = 1'b0,
    REQ_SEARCH    = 1'b1
  } req_t;

  typedef struct packed {
    logic   ok;
    coord_t x;
    coord_t y;
  } nb_t;

  // datapath commands from the sequencer
  typedef struct packed {
    logic map_wr;
    logic load;
    logic visit;
    logic rlx_rd;
    logic rlx_wr;
    logic scan_init;
    logic vl_rd;
    logic nb_rd;
    logic nb_cmp;
    logic round_end;
    logic path_init;
    logic par_rd;
    logic par_push;
    logic emit_init;
    logic emit_rd;
    logic emit_ld;
    logic single_ld;
    logic single_found;
  } cmd_t;

  typedef struct packed {
    logic at_goal;
    logic same_sg;
    logic k_last;
    logic i_last;
    logic rounds_done;
    logic path_done;
    logic emit_last;
    logic out_free;
  } sts_t;

  // neighbour of (x, y) in direction k, ok clear when it leaves the grid
  function automatic nb_t nb_of(input coord_t x, input coord_t y, input nb_dir_t k);
    nb_t r;
    r.ok = 1'b1;
    r.x  = x;
    r.y  = y;
    unique case (k)
      NB_UP: begin
        r.ok = (y != '0);
        r.y  = y - 1'b1;
      end
      NB_LEFT: begin
        r.ok = (x != '0);
        r.x  = x - 1'b1;
      end
      NB_RIGHT: begin
        r.ok = (x != coord_t'(GridW - 1));
        r.x  = x + 1'b1;
      end
      NB_DOWN: begin
        r.ok = (y != coord_t'(GridH - 1));
        r.y  = y + 1'b1;
      end
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

endpackage

### rtl/grid_astar_path_search_unit.sv
`timescale 1ns / 1ps
// 8x8 grid path search, four neighbours with a manhattan estimate. a map word
// (tuser 0) loads one row of the walkable bitmap. a search word (tuser 1) runs
// up to 64 rounds; each round's scan reads every cell in the visit list and
// the single-port weight memory once per neighbour. a found path is then
// traced back and sent out, path cells from the first step after the start to
// the goal, tlast on the goal. start equal to goal gives one word with found
// set and no cell; failure gives one word with found clear. input is taken
// only while no search is running.
module grid_astar_path_search_unit import gaps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // row_index[2:0] row_walkable[10:3] start_x[13:11] start_y[16:14]
  // goal_x[19:17] goal_y[22:20]
  input  logic [23:0] in_tdata,
  // req_type[0]
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // cell_x[2:0] cell_y[5:3]
  output logic [7:0]  out_tdata,
  // found[0] has_cell[1]
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);

  cmd_t   cmd;
  sts_t   sts;
  coord_t cell_x, cell_y;
  logic   found, has_cell;

  gaps_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_req_type (in_tuser[0]),
    .in_ready    (in_tready),
    .sts         (sts),
    .cmd         (cmd)
  );

  gaps_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_row_index    (in_tdata[2:0]),
    .in_row_walkable (in_tdata[10:3]),
    .in_start_x      (in_tdata[13:11]),
    .in_start_y      (in_tdata[16:14]),
    .in_goal_x       (in_tdata[19:17]),
    .in_goal_y       (in_tdata[22:20]),
    .out_ready       (out_tready),
    .out_valid       (out_tvalid),
    .out_found       (found),
    .out_has_cell    (has_cell),
    .out_cell_x      (cell_x),
    .out_cell_y      (cell_y),
    .out_last        (out_tlast)
  );

  assign out_tdata = {2'b00, cell_y, cell_x};
  assign out_tuser = {has_cell, found};

endmodule

### rtl/gaps_ctrl.sv
`timescale 1ns / 1ps
module gaps_ctrl import gaps_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_req_type,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [13:0] {
    ST_IDLE      = 14'b00000000000001,
    ST_VISIT     = 14'b00000000000010,
    ST_RLX_RD    = 14'b00000000000100,
    ST_RLX_WR    = 14'b00000000001000,
    ST_SCAN_VL   = 14'b00000000010000,
    ST_SCAN_RD   = 14'b00000000100000,
    ST_SCAN_CMP  = 14'b00000001000000,
    ST_ROUND_END = 14'b00000010000000,
    ST_PATH      = 14'b00000100000000,
    ST_PATH_PUSH = 14'b00001000000000,
    ST_EMIT_RD   = 14'b00010000000000,
    ST_EMIT      = 14'b00100000000000,
    ST_FAIL      = 14'b01000000000000,
    ST_EMPTY     = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (req_t'(in_req_type) == REQ_SEARCH) begin
            cmd.load  = 1'b1;
            state_nxt = ST_VISIT;
          end else begin
            cmd.map_wr = 1'b1;
          end
        end
      end
      ST_VISIT: begin
        cmd.visit = 1'b1;
        if (sts.at_goal) begin
          if (sts.same_sg) begin
            state_nxt = ST_EMPTY;
          end else begin
            cmd.path_init = 1'b1;
            state_nxt     = ST_PATH;
          end
        end else begin
          state_nxt = ST_RLX_RD;
        end
      end
      ST_RLX_RD: begin
        cmd.rlx_rd = 1'b1;
        state_nxt  = ST_RLX_WR;
      end
      ST_RLX_WR: begin
        cmd.rlx_wr = 1'b1;
        if (sts.k_last) begin
          cmd.scan_init = 1'b1;
          state_nxt     = ST_SCAN_VL;
        end else begin
          state_nxt = ST_RLX_RD;
        end
      end
      ST_SCAN_VL: begin
        cmd.vl_rd = 1'b1;
        state_nxt = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        cmd.nb_rd = 1'b1;
        state_nxt = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        cmd.nb_cmp = 1'b1;
        priority if (sts.k_last && sts.i_last) state_nxt = ST_ROUND_END;
        else if (sts.k_last)                   state_nxt = ST_SCAN_VL;
        else                                   state_nxt = ST_SCAN_RD;
      end
      ST_ROUND_END: begin
        cmd.round_end = 1'b1;
        state_nxt     = sts.rounds_done ? ST_FAIL : ST_VISIT;
      end
      ST_PATH: begin
        if (sts.path_done) begin
          cmd.emit_init = 1'b1;
          state_nxt     = ST_EMIT_RD;
        end else begin
          cmd.par_rd = 1'b1;
          state_nxt  = ST_PATH_PUSH;
        end
      end
      ST_PATH_PUSH: begin
        cmd.par_push = 1'b1;
        state_nxt    = ST_PATH;
      end
      ST_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_ld = 1'b1;
          state_nxt   = sts.emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      ST_FAIL: begin
        if (sts.out_free) begin
          cmd.single_ld = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (sts.out_free) begin
          cmd.single_ld    = 1'b1;
          cmd.single_found = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/gaps_dp.sv
`timescale 1ns / 1ps
module gaps_dp import gaps_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  cmd_t         cmd,
  output sts_t         sts,
  input  coord_t       in_row_index,
  input  logic [GridW-1:0] in_row_walkable,
  input  coord_t       in_start_x,
  input  coord_t       in_start_y,
  input  coord_t       in_goal_x,
  input  coord_t       in_goal_y,
  input  logic         out_ready,
  output logic         out_valid,
  output logic         out_found,
  output logic         out_has_cell,
  output coord_t       out_cell_x,
  output coord_t       out_cell_y,
  output logic         out_last
);

  logic [GridH-1:0][GridW-1:0] map_r;
  logic [NCells-1:0] visited_r;
  logic [NCells-1:0] wvalid_r;

  cell_t               cur_r, start_r, goal_r, bestc_r, d_r;
  logic [WeightW-1:0]  cw_r, bestw_r;
  logic [CountW-1:0]   vcount_r, n_r;
  logic [CellW-1:0]    round_r, i_r, e_r;
  logic [1:0]          k_r;
  logic [ScoreW-1:0]   best_r;
  logic                any_r;

  logic [WeightW-1:0] wmem [NCells];
  cell_t              pmem [NCells];
  cell_t              vmem [NCells];
  cell_t              smem [NCells];

  logic [WeightW-1:0] wq_r;
  logic               wvq_r;
  cell_t              pq_r, vlq_r, sq_r;

  cell_t              base;
  nb_t                nb;
  cell_t              nb_cell;
  logic               walk, vis, hit, better;
  logic [WeightW-1:0] w_eff, cw10;
  coord_t             dx, dy;
  logic [CoordW:0]    manh;
  logic [ScoreW-1:0]  score;

  // scan walks neighbours of visit-list entries, relax those of the current cell
  assign base    = (cmd.nb_rd || cmd.nb_cmp) ? vlq_r : cur_r;
  assign nb      = nb_of(base[CoordW-1:0], base[CellW-1:CoordW], nb_dir_t'(k_r));
  assign nb_cell = {nb.y, nb.x};
  assign walk    = nb.ok && map_r[nb.y][nb.x];
  assign vis     = visited_r[nb_cell];
  assign w_eff   = wvq_r ? wq_r : InitWeight;
  assign cw10    = cw_r + StepCost;
  assign hit     = walk && !vis && (w_eff > cw10);

  assign dx    = (goal_r[CoordW-1:0] > nb.x) ? goal_r[CoordW-1:0] - nb.x
                                             : nb.x - goal_r[CoordW-1:0];
  assign dy    = (goal_r[CellW-1:CoordW] > nb.y) ? goal_r[CellW-1:CoordW] - nb.y
                                                 : nb.y - goal_r[CellW-1:CoordW];
  assign manh  = {1'b0, dx} + {1'b0, dy};
  assign score = ScoreW'(w_eff) + (ScoreW'(manh) << 3) + (ScoreW'(manh) << 1);
  assign better = walk && !vis && (score < best_r);

  assign sts.at_goal     = (cur_r == goal_r);
  assign sts.same_sg     = (start_r == goal_r);
  assign sts.k_last      = (k_r == 2'(NB_DOWN));
  assign sts.i_last      = ({1'b0, i_r} == vcount_r - 1'b1);
  assign sts.rounds_done = (round_r == CellW'(NCells - 1));
  assign sts.path_done   = (d_r == start_r) || (n_r == CountW'(NCells));
  assign sts.emit_last   = (e_r == '0);
  assign sts.out_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r     <= '0;
      visited_r <= '0;
      wvalid_r  <= '0;
      vcount_r  <= '0;
      round_r   <= '0;
      k_r       <= '0;
      i_r       <= '0;
      any_r     <= 1'b0;
      n_r       <= '0;
      e_r       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.map_wr) begin
        map_r[in_row_index] <= in_row_walkable;
      end
      if (cmd.load) begin
        visited_r <= '0;
        wvalid_r  <= NCells'(1) << {in_start_y, in_start_x};
        vcount_r  <= '0;
        round_r   <= '0;
      end
      if (cmd.visit) begin
        visited_r[cur_r] <= 1'b1;
        if (!vcount_r[CountW-1]) begin
          vcount_r <= vcount_r + 1'b1;
        end
        k_r <= '0;
      end
      if (cmd.rlx_wr) begin
        k_r <= k_r + 1'b1;
        if (hit) begin
          wvalid_r[nb_cell] <= 1'b1;
        end
      end
      if (cmd.scan_init) begin
        i_r   <= '0;
        any_r <= 1'b0;
      end
      if (cmd.nb_cmp) begin
        k_r <= k_r + 1'b1;
        if (k_r == 2'(NB_DOWN)) begin
          i_r <= i_r + 1'b1;
        end
        if (better) begin
          any_r <= 1'b1;
        end
      end
      if (cmd.round_end) begin
        round_r <= round_r + 1'b1;
      end
      if (cmd.path_init) begin
        n_r <= CountW'(1);
      end
      if (cmd.par_push) begin
        n_r <= n_r + 1'b1;
      end
      if (cmd.emit_init) begin
        e_r <= CellW'(n_r - CountW'(2));
      end
      if (cmd.emit_ld) begin
        e_r <= e_r - 1'b1;
      end
      if (cmd.emit_ld || cmd.single_ld) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      start_r <= {in_start_y, in_start_x};
      goal_r  <= {in_goal_y, in_goal_x};
      cur_r   <= {in_start_y, in_start_x};
      cw_r    <= '0;
    end
    if (cmd.scan_init) begin
      best_r <= '1;
    end
    if (cmd.nb_cmp && better) begin
      best_r  <= score;
      bestc_r <= nb_cell;
      bestw_r <= w_eff;
    end
    if (cmd.round_end && any_r) begin
      cur_r <= bestc_r;
      cw_r  <= bestw_r;
    end
    if (cmd.path_init) begin
      d_r <= goal_r;
    end
    if (cmd.par_push) begin
      d_r <= pq_r;
    end
    if (cmd.emit_ld) begin
      out_found    <= 1'b1;
      out_has_cell <= 1'b1;
      out_cell_x   <= sq_r[CoordW-1:0];
      out_cell_y   <= sq_r[CellW-1:CoordW];
      out_last     <= (e_r == '0);
    end else if (cmd.single_ld) begin
      out_found    <= cmd.single_found;
      out_has_cell <= 1'b0;
      out_cell_x   <= '0;
      out_cell_y   <= '0;
      out_last     <= 1'b1;
    end
  end

  // weight memory, absent entries read as the initial weight
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wmem[{in_start_y, in_start_x}] <= '0;
    end else if (cmd.rlx_wr && hit) begin
      wmem[nb_cell] <= cw10;
    end
    if (cmd.rlx_rd || cmd.nb_rd) begin
      wq_r  <= wmem[nb_cell];
      wvq_r <= wvalid_r[nb_cell];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rlx_wr && hit) begin
      pmem[nb_cell] <= cur_r;
    end
    if (cmd.par_rd) begin
      pq_r <= pmem[d_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.visit && !vcount_r[CountW-1]) begin
      vmem[vcount_r[CellW-1:0]] <= cur_r;
    end
    if (cmd.vl_rd) begin
      vlq_r <= vmem[i_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.path_init) begin
      smem[0] <= goal_r;
    end else if (cmd.par_push) begin
      smem[n_r[CellW-1:0]] <= pq_r;
    end
    if (cmd.emit_rd) begin
      sq_r <= smem[e_r];
    end
  end

endmodule

### rtl/gaps_checker.sv
`timescale 1ns / 1ps
module gaps_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast
);

  // a stalled word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word withdrawn while stalled");

  // a word without a cell closes the search
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> out_tlast)
    else $error("cell-less word without tlast");

  a_fail_no_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> !out_tuser[1])
    else $error("cell given on a failed search");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> out_tdata == 8'd0)
    else $error("cell-less word carries cell bits");

endmodule

bind grid_astar_path_search_unit gaps_checker u_gaps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
